@@ rtl/tksd_pkg.sv @@
// tksd_pkg: key codes, byte constants and the key sequence table shared by
// the terminal key sequence decoder and its decode stage
// no dependencies
package tksd_pkg;

  localparam int PENDING_DEPTH_DEF = 8;
  localparam int NUM_SEQS          = 12;
  localparam int SEQ_MAX           = 4;
  localparam int SEQ_LEN_W         = 3;

  localparam logic [3:0] KEY_NONE       = 4'd0;
  localparam logic [3:0] KEY_PRINTABLE  = 4'd1;
  localparam logic [3:0] KEY_ENTER      = 4'd2;
  localparam logic [3:0] KEY_TABLE_BASE = 4'd3;

  localparam logic [7:0] CH_ESC     = 8'h1B;
  localparam logic [7:0] CH_LBRACK  = 8'h5B;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] PRINT_LO   = 8'h20;
  localparam logic [7:0] PRINT_HI   = 8'h7E;
  localparam logic [7:0] CH_DEL     = 8'h7F;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_BS      = 8'h08;
  localparam logic [7:0] CH_UPPER_K = 8'h4B;
  localparam logic [7:0] CH_TWO     = 8'h32;
  localparam logic [7:0] CH_UPPER_J = 8'h4A;
  localparam logic [7:0] CH_UPPER_H = 8'h48;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_B = 8'h42;
  localparam logic [7:0] CH_UPPER_C = 8'h43;
  localparam logic [7:0] CH_UPPER_D = 8'h44;
  localparam logic [7:0] CH_SOH     = 8'h01;
  localparam logic [7:0] CH_NUL     = 8'h00;

  typedef struct packed {
    logic [3:0] key;
    logic       update;
    logic       clear;
  } tksd_dec_t;

  // sequence bytes, first byte in the top bits
  function automatic logic [8*SEQ_MAX-1:0] seq_word(input logic [3:0] k);
    logic [8*SEQ_MAX-1:0] w;
    case (k)
      4'd0:    w = {CH_ESC, CH_LBRACK, CH_UPPER_A, CH_NUL};
      4'd1:    w = {CH_ESC, CH_LBRACK, CH_UPPER_B, CH_NUL};
      4'd2:    w = {CH_ESC, CH_LBRACK, CH_UPPER_D, CH_NUL};
      4'd3:    w = {CH_ESC, CH_LBRACK, CH_UPPER_C, CH_NUL};
      4'd4:    w = {CH_TAB, CH_NUL, CH_NUL, CH_NUL};
      4'd5:    w = {CH_BS, CH_NUL, CH_NUL, CH_NUL};
      4'd6:    w = {CH_DEL, CH_NUL, CH_NUL, CH_NUL};
      4'd7:    w = {CH_ESC, CH_LBRACK, CH_UPPER_K, CH_NUL};
      4'd8:    w = {CH_ESC, CH_LBRACK, CH_TWO, CH_UPPER_K};
      4'd9:    w = {CH_ESC, CH_LBRACK, CH_SOH, CH_UPPER_D};
      4'd10:   w = {CH_ESC, CH_LBRACK, CH_TWO, CH_UPPER_J};
      4'd11:   w = {CH_ESC, CH_LBRACK, CH_UPPER_H, CH_NUL};
      default: w = '0;
    endcase
    return w;
  endfunction

  function automatic logic [SEQ_LEN_W-1:0] seq_len(input logic [3:0] k);
    logic [SEQ_LEN_W-1:0] n;
    case (k)
      4'd4, 4'd5, 4'd6:   n = 3'd1;
      4'd8, 4'd9, 4'd10:  n = 3'd4;
      4'd0, 4'd1, 4'd2, 4'd3, 4'd7, 4'd11: n = 3'd3;
      default:            n = 3'd0;
    endcase
    return n;
  endfunction

endpackage

@@ rtl/tksd_decode.sv @@
// tksd_decode: classifies one byte as printable or enter, or appends it to the
// pending sequence and matches that against the key table; depends on tksd_pkg
module tksd_decode #(
  parameter int PENDING_DEPTH = tksd_pkg::PENDING_DEPTH_DEF,
  localparam int CNT_W = $clog2(PENDING_DEPTH + 1)
) (
  input  logic [7:0]                           rx_byte,
  input  logic [tksd_pkg::SEQ_MAX-1:0][7:0]    pend_bytes,
  input  logic [CNT_W-1:0]                     pend_count,
  output logic [tksd_pkg::SEQ_MAX-1:0][7:0]    bytes_next,
  output tksd_pkg::tksd_dec_t                  dec
);

  logic [tksd_pkg::SEQ_MAX-1:0][7:0]     bytes_app;
  logic [CNT_W-1:0]                      count_inc;
  logic [8*tksd_pkg::SEQ_MAX-1:0]        word;
  logic [tksd_pkg::SEQ_LEN_W-1:0]        len;
  logic                                  same;
  logic                                  found;
  logic [3:0]                            key_hit;
  logic                                  printable;

  always_comb begin
    bytes_app = pend_bytes;
    for (int i = 0; i < tksd_pkg::SEQ_MAX; i++) begin
      if (pend_count == CNT_W'(i)) begin
        bytes_app[i] = rx_byte;
      end
    end
    count_inc = pend_count + CNT_W'(1);

    found   = 1'b0;
    key_hit = tksd_pkg::KEY_NONE;
    word    = '0;
    len     = '0;
    same    = 1'b0;
    for (int k = 0; k < tksd_pkg::NUM_SEQS; k++) begin
      word = tksd_pkg::seq_word(4'(k));
      len  = tksd_pkg::seq_len(4'(k));
      same = (count_inc == CNT_W'(len));
      for (int i = 0; i < tksd_pkg::SEQ_MAX; i++) begin
        if ((3'(i) < len) && (bytes_app[i] != word[8*(tksd_pkg::SEQ_MAX-i)-1 -: 8])) begin
          same = 1'b0;
        end
      end
      if (same && !found) begin
        found   = 1'b1;
        key_hit = tksd_pkg::KEY_TABLE_BASE + 4'(k);
      end
    end
  end

  assign printable = rx_byte inside {[tksd_pkg::PRINT_LO:tksd_pkg::PRINT_HI]};

  always_comb begin
    dec.key    = tksd_pkg::KEY_NONE;
    dec.update = 1'b0;
    dec.clear  = 1'b0;
    if (printable && (pend_count == '0)) begin
      dec.key = tksd_pkg::KEY_PRINTABLE;
    end else if (rx_byte == tksd_pkg::CH_CR) begin
      dec.key = tksd_pkg::KEY_ENTER;
    end else begin
      dec.update = 1'b1;
      if (found) begin
        dec.key   = key_hit;
        dec.clear = 1'b1;
      end else if (count_inc == CNT_W'(PENDING_DEPTH)) begin
        dec.clear = 1'b1;
      end
    end
  end

  assign bytes_next = bytes_app;

endmodule

@@ rtl/terminal_key_sequence_decoder.sv @@
// terminal_key_sequence_decoder: input word register, pending sequence
// state and key code output register; depends on tksd_pkg, tksd_decode
//
//   channel  handshake             payload
//   input    in_valid / in_stall   rx_byte  [7:0]
//   output   out_valid / out_stall key_code [3:0]
//
// one word per cycle while the output is not stalled; a word is decoded from
// the input register after it is taken, and its key code is registered into
// the output register when the output advances
// the pending count updates at the same edge as the key code, so back to back words see it
// rst clears the pending count and both valid flags
// a stalled output holds the input register, which then stalls the input
module terminal_key_sequence_decoder #(
  parameter int PENDING_DEPTH = tksd_pkg::PENDING_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] key_code
);

  localparam int CNT_W = $clog2(PENDING_DEPTH + 1);

  logic                                 in_full;
  logic [7:0]                           in_byte;
  logic [tksd_pkg::SEQ_MAX-1:0][7:0]    pend_bytes;
  logic [tksd_pkg::SEQ_MAX-1:0][7:0]    bytes_next;
  logic [CNT_W-1:0]                     pend_count;
  logic [CNT_W-1:0]                     pend_count_next;
  tksd_pkg::tksd_dec_t                  dec;
  logic                                 adv;

  tksd_decode #(
    .PENDING_DEPTH(PENDING_DEPTH)
  ) u_decode (
    .rx_byte    (in_byte),
    .pend_bytes (pend_bytes),
    .pend_count (pend_count),
    .bytes_next (bytes_next),
    .dec        (dec)
  );

  assign adv      = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !adv;

  always_comb begin
    pend_count_next = pend_count;
    if (dec.clear) begin
      pend_count_next = '0;
    end else if (dec.update) begin
      pend_count_next = pend_count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full    <= 1'b0;
      out_valid  <= 1'b0;
      pend_count <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        in_full <= 1'b1;
      end else if (adv) begin
        in_full <= 1'b0;
      end
      if (adv) begin
        out_valid  <= 1'b1;
        pend_count <= pend_count_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte <= rx_byte;
    end
    if (adv) begin
      key_code <= dec.key;
      if (dec.update) begin
        pend_bytes <= bytes_next;
      end
    end
  end

  // pending count never reaches the depth between words
  assert property (@(posedge clk) disable iff (rst)
    pend_count < CNT_W'(PENDING_DEPTH))
    else $error("pending count at or above depth");

  // input stall only when the output register is full and held
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (in_full && out_valid && out_stall))
    else $error("input stalled without output back pressure");

  // a table key empties the pending sequence
  assert property (@(posedge clk) disable iff (rst)
    (adv && (dec.key >= tksd_pkg::KEY_TABLE_BASE)) |=> (pend_count == '0))
    else $error("pending sequence kept after key match");

  // printable and enter leave the pending sequence alone
  assert property (@(posedge clk) disable iff (rst)
    (adv && ((dec.key == tksd_pkg::KEY_PRINTABLE) || (dec.key == tksd_pkg::KEY_ENTER)))
      |=> (pend_count == $past(pend_count)))
    else $error("pending count changed on printable or enter");

endmodule
